[rtl/pee_pkg.sv]
// ----------------------------------------------------------------------------
// pee_pkg : shared types and constants of the postfix expression evaluator
// Token codes, status codes, sequencer states and the divider request and
// response bundles.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 4;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;   // op + value, padded to whole bytes
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = STATUS_W;
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_DIV  = 4'd4,
        OP_EQ   = 4'd5,
        OP_NE   = 4'd6,
        OP_LT   = 4'd7,
        OP_GT   = 4'd8,
        OP_LE   = 4'd9,
        OP_GE   = 4'd10,
        OP_AND  = 4'd11,
        OP_OR   = 4'd12,
        OP_XOR  = 4'd13,
        OP_NOT  = 4'd14,
        OP_NOP  = 4'd15
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIV0  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_R,
        S_POP_L,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_TOP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/pee_ram.sv]
// ----------------------------------------------------------------------------
// pee_ram : generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/pee_alu.sv]
// ----------------------------------------------------------------------------
// pee_alu : combinational operator unit
// Add, subtract, low-word multiply, signed compares, bitwise logic and NOT.
// Division is handled by the iterative divider.
// ----------------------------------------------------------------------------
module pee_alu (
    input  pee_pkg::t_op                i_op,
    input  logic [pee_pkg::DATA_W-1:0]  i_lhs,
    input  logic [pee_pkg::DATA_W-1:0]  i_rhs,
    output logic [pee_pkg::DATA_W-1:0]  o_result
);
    import pee_pkg::*;

    logic [DATA_W-1:0] w_prod;
    logic              w_eq;
    logic              w_lt;

    assign w_prod = i_lhs * i_rhs;
    assign w_eq   = (i_lhs == i_rhs);
    assign w_lt   = ($signed(i_lhs) < $signed(i_rhs));

    always_comb begin
        unique case (i_op)
            OP_ADD:  o_result = i_lhs + i_rhs;
            OP_SUB:  o_result = i_lhs - i_rhs;
            OP_MUL:  o_result = w_prod;
            OP_EQ:   o_result = {{(DATA_W-1){1'b0}}, w_eq};
            OP_NE:   o_result = {{(DATA_W-1){1'b0}}, !w_eq};
            OP_LT:   o_result = {{(DATA_W-1){1'b0}}, w_lt};
            OP_GT:   o_result = {{(DATA_W-1){1'b0}}, !w_lt && !w_eq};
            OP_LE:   o_result = {{(DATA_W-1){1'b0}}, w_lt || w_eq};
            OP_GE:   o_result = {{(DATA_W-1){1'b0}}, !w_lt};
            OP_AND:  o_result = i_lhs & i_rhs;
            OP_OR:   o_result = i_lhs | i_rhs;
            OP_XOR:  o_result = i_lhs ^ i_rhs;
            OP_NOT:  o_result = ~i_lhs;
            default: o_result = '0;
        endcase
    end

endmodule

[rtl/pee_div.sv]
// ----------------------------------------------------------------------------
// pee_div : iterative signed divider, truncating toward zero
// Restoring division on magnitudes, one quotient bit per cycle. The divisor
// must be non-zero; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module pee_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pee_pkg::t_div_req i_req,
    output pee_pkg::t_div_rsp o_rsp
);
    import pee_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_den;
    logic                 r_neg;

    logic [DATA_W:0]      w_shift;
    logic [DATA_W:0]      w_diff;
    logic                 w_fits;
    logic [DATA_W-1:0]    w_mag_a;
    logic [DATA_W-1:0]    w_mag_b;

    assign w_mag_a = i_req.dividend[DATA_W-1] ? (DATA_W'(0) - i_req.dividend)
                                              : i_req.dividend;
    assign w_mag_b = i_req.divisor[DATA_W-1]  ? (DATA_W'(0) - i_req.divisor)
                                              : i_req.divisor;

    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fits  = !w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= DIV_CNT_W'(DATA_W - 1);
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_den <= w_mag_b;
            r_neg <= i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= w_fits ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

[rtl/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator : postfix token evaluator on a RAM stack
// Evaluates a stream of postfix tokens on an operand stack of signed 32-bit
// integers and returns the stack top and a sticky status at the last token.
// ----------------------------------------------------------------------------
// The block takes one token per input beat and works on it until it is done
// before it accepts the next. A push writes the value to the stack; NOT does
// one stack read, a compute step and a write back, and every binary operator
// other than divide does two stack reads through the one read port of the
// stack RAM, a compute step and a write back; a divide waits on the 32-step
// iterative divider, and a divide by zero skips it. A token marked last then
// reads the stack top and loads the result register, waiting only while an
// earlier result beat is still waiting to be taken. The result register parts
// the two sides, so tokens are accepted while a result waits downstream. Every
// expression starts with a single zero on the stack; a flag marks the bottom
// entry as reading zero until it is written, so no clearing pass is needed
// after reset or between expressions. Errors are sticky: the first of stack
// underflow (a missing operand reads as zero), stack overflow (the push is
// dropped) or divide by zero (the quotient is zero) is reported with the
// result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Token beats
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pee_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [3:0] op, [35:4] value
    input  logic                                s_axis_tlast,  // last_token
    // Result beats
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pee_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [31:0] result
    output logic [pee_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // [1:0] status
);
    import pee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer and stack bookkeeping.
    t_state            r_state, n_state;
    t_op               r_op;
    logic              r_last;
    logic [CW-1:0]     r_count, n_count;
    t_status           r_status, n_status;
    logic              r_base_zero, n_base_zero;  // bottom entry reads as zero
    logic              r_pop_zero, n_pop_zero;    // last read yields zero
    logic [DATA_W-1:0] r_rhs, n_rhs;
    logic [DATA_W-1:0] r_res, n_res;

    // Result register.
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_result, n_out_result;
    t_status           r_out_status, n_out_status;

    // Stack RAM port.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              in_accept;
    t_op               in_op;
    logic              out_free;
    logic [CW-1:0]     cnt_m1;
    logic [DATA_W-1:0] rd_val;
    logic [DATA_W-1:0] alu_result;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = t_op'(s_axis_tdata[OP_W-1:0]);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign cnt_m1        = r_count - CW'(1);

    // The value of the entry read in the previous state; an empty-stack pop
    // and an unwritten bottom entry both read as zero.
    assign rd_val = r_pop_zero ? '0 : ram_rdata;

    pee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The left operand arrives straight from the RAM; the right one was
    // captured into a register in the state before. NOT sees its operand on the left input.
    pee_alu u_alu (
        .i_op     (r_op),
        .i_lhs    (rd_val),
        .i_rhs    (r_rhs),
        .o_result (alu_result)
    );

    pee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (in_op) inside
                        OP_PUSH: n_state = S_PUSH;
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_LT,
                        OP_GT, OP_LE, OP_GE, OP_AND, OP_OR, OP_XOR,
                        OP_NOT:  n_state = S_POP_R;
                        default: n_state = s_axis_tlast ? S_TOP : S_IDLE;
                    endcase
                end
            end
            S_POP_R: n_state = (r_op == OP_NOT) ? S_EXEC : S_POP_L;
            S_POP_L: n_state = S_EXEC;
            S_EXEC:  n_state = (r_op == OP_DIV && r_rhs != '0) ? S_DIV : S_PUSH;
            S_DIV:   n_state = div_rsp.done ? S_PUSH : S_DIV;
            S_PUSH:  n_state = r_last ? S_TOP : S_IDLE;
            S_TOP:   n_state = S_EMIT;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and stack control. A pop reads entry count-1 and the data is
    // used in the following state; reads and writes never fall in the same
    // cycle, so no forwarding is needed.
    always_comb begin
        n_count      = r_count;
        n_status     = r_status;
        n_base_zero  = r_base_zero;
        n_pop_zero   = r_pop_zero;
        n_rhs        = r_rhs;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_result = r_out_result;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = r_res;
        ram_re       = 1'b0;
        ram_raddr    = cnt_m1[AW-1:0];
        div_req      = '{start: 1'b0, dividend: rd_val, divisor: r_rhs};

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_res = s_axis_tdata[OP_W +: DATA_W];
                end
            end
            S_POP_R, S_POP_L, S_TOP: begin
                if (r_state == S_POP_L) begin
                    n_rhs = rd_val;
                end
                if (r_count == '0) begin
                    n_pop_zero = 1'b1;
                    if (r_status == ST_OK) begin
                        n_status = ST_UNDER;
                    end
                end else begin
                    ram_re     = 1'b1;
                    n_pop_zero = (cnt_m1 == '0) && r_base_zero;
                    if (r_state != S_TOP) begin
                        n_count = cnt_m1;
                    end
                end
            end
            S_EXEC: begin
                if (r_op == OP_DIV) begin
                    n_res = '0;
                    if (r_rhs == '0) begin
                        if (r_status == ST_OK) begin
                            n_status = ST_DIV0;
                        end
                    end else begin
                        div_req.start = 1'b1;
                    end
                end else begin
                    n_res = alu_result;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res = div_rsp.quotient;
                end
            end
            S_PUSH: begin
                if (r_count < CW'(STACK_DEPTH)) begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    if (r_count == '0) begin
                        n_base_zero = 1'b0;
                    end
                end else if (r_status == ST_OK) begin
                    n_status = ST_OVER;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_result = rd_val;
                    n_out_status = r_status;
                    // Back to a single zero on the stack.
                    n_count      = CW'(1);
                    n_status     = ST_OK;
                    n_base_zero  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= CW'(1);
            r_status    <= ST_OK;
            r_base_zero <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_status    <= n_status;
            r_base_zero <= n_base_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= in_op;
            r_last <= s_axis_tlast;
        end
        r_pop_zero   <= n_pop_zero;
        r_rhs        <= n_rhs;
        r_res        <= n_res;
        r_out_result <= n_out_result;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_result;
    assign m_axis_tuser  = r_out_status;

    // The stack never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // The sequencer never reads and writes the stack RAM in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("stack read and write overlap");

    // Once recorded, an error stays until the result is handed over.
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_OK && !(r_state == S_EMIT && out_free))
        |=> (r_status == $past(r_status)))
        else $error("sticky status changed");

    // Handing over a result returns the stack to a single zero entry.
    a_expr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free)
        |=> (r_count == CW'(1) && r_status == ST_OK && r_base_zero && r_out_valid))
        else $error("stack not restarted after result");

    // The divider only completes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

endmodule
